[sv/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, operation and status codes and constants of the TLV section
// store.
// ----------------------------------------------------------------------------
package tss_pkg;

   localparam int PAYLOAD_WORDS = 256;
   localparam int WORD_AW       = $clog2(PAYLOAD_WORDS);
   localparam int PTR_W         = WORD_AW + 1;
   localparam int CAP_BYTES     = PAYLOAD_WORDS * 4;
   // Byte sums such as offset + 8 + size need 18 bits at the largest capacity.
   localparam int SUM_W         = 18;

   localparam logic [2:0] OP_WRITE_WORD = 3'd0;
   localparam logic [2:0] OP_SET_HEADER = 3'd1;
   localparam logic [2:0] OP_CLEAR      = 3'd2;
   localparam logic [2:0] OP_APPEND     = 3'd3;
   localparam logic [2:0] OP_FIND       = 3'd4;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_HEADER = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
   localparam logic [2:0] ST_SIZE_DIFF  = 3'd3;
   localparam logic [2:0] ST_MALFORMED  = 3'd4;
   localparam logic [2:0] ST_NO_ROOM    = 3'd5;

   localparam int         CSR_IDX_W   = 1;
   localparam logic [0:0] CSR_MAGIC   = 1'b0;
   localparam logic [0:0] CSR_VERSION = 1'b1;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  word_index;
      logic [31:0] word_data;
      logic [31:0] header_magic;
      logic [31:0] header_version;
      logic [15:0] header_payload_size;
      logic [31:0] section_id;
      logic [15:0] section_size;
   } tss_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [9:0] data_offset;
   } tss_rsp_type;

   // Record length: 8 + size rounded up to a multiple of four, modulo 65536.
   function automatic logic [15:0] rec_len(input logic [15:0] size);
      logic [15:0] s;
      logic [15:0] r;
      s = 16'd8 + size;
      r = (s + 16'd3) & ~16'd3;
      return r;
   endfunction

endpackage

[sv/tlv_section_store_top.sv]
// ----------------------------------------------------------------------------
// tlv_section_store_top
// Word-addressed store of type-length-value records with a small header,
// held in one synchronous payload memory.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid/req_ready/req_data) takes one word per
//   operation: write a payload word, set the header, clear, append a record
//   or find a record. Every request gives exactly one word on the response
//   channel (rsp_valid/rsp_ready/rsp_data) with a status and a data offset.
//   The csr_ port loads the expected magic and version; write it only while
//   the block is idle.
//   Word write, set header, clear, a rejected append and a find with a bad
//   header answer in the cycle after acceptance. An append does one
//   read-modify-write per payload word touched. A find walks the records in
//   turn through S_FLOOP, S_FRID, S_FRSZ and S_FEVAL, as each takes two reads.
//   Only one request is in flight; the next one is taken in the cycle its
//   predecessor's response is taken, or while the response slot is empty.
//   Reset clears the header, the expected values and per-word valid bits, so
//   the payload reads as zero at once, with no clearing pass. A stalled
//   receiver holds the response register and blocks new requests.
// ----------------------------------------------------------------------------
module tlv_section_store_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tss_pkg::tss_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tss_pkg::tss_rsp_type              rsp_data,
   input  logic                              csr_wr_en,
   input  logic [tss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_wdata
);
   import tss_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_APPEND = 3'd1;
   localparam logic [2:0] S_FLOOP  = 3'd2;
   localparam logic [2:0] S_FRID   = 3'd3;
   localparam logic [2:0] S_FRSZ   = 3'd4;
   localparam logic [2:0] S_FEVAL  = 3'd5;

   localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAP_BYTES);
   localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(PAYLOAD_WORDS - 1);

   logic [2:0]          state_ff, state_in;
   logic [31:0]         exp_magic_ff, exp_magic_in;
   logic [31:0]         exp_version_ff, exp_version_in;
   logic [31:0]         st_magic_ff, st_magic_in;
   logic [31:0]         st_version_ff, st_version_in;
   logic [15:0]         used_ff, used_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tss_rsp_type         rsp_data_ff, rsp_data_in;

   // Payload memory with per-word valid bits; an invalid word reads as zero.
   logic [31:0]         mem_q [PAYLOAD_WORDS];
   logic [PAYLOAD_WORDS-1:0] valid_ff;
   logic [31:0]         rd_data_ff;
   logic                rd_vld_ff;
   logic                mem_we, mem_re, clr_all;
   logic [WORD_AW-1:0]  mem_waddr, mem_raddr;
   logic [31:0]         mem_wdata;
   logic [31:0]         rd_word;

   // Append sequencer.
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [WORD_AW-1:0]  last_ff, last_in;
   logic [SUM_W-1:0]    base_ff, base_in;
   logic [SUM_W-1:0]    endb_ff, endb_in;
   logic [SUM_W-1:0]    hdr_end_ff, hdr_end_in;
   logic [63:0]         hdr_ff, hdr_in;
   logic                wb_valid_ff, wb_valid_in;
   logic [WORD_AW-1:0]  wb_addr_ff, wb_addr_in;
   logic [15:0]         app_used_ff, app_used_in;
   logic [9:0]          app_offs_ff, app_offs_in;

   // Find walker.
   logic [15:0]         pos_ff, pos_in;
   logic [31:0]         fid_ff, fid_in;
   logic [15:0]         fsize_ff, fsize_in;
   logic [31:0]         rid_ff, rid_in;

   logic                accept;
   logic                done;
   tss_rsp_type         result;
   logic [15:0]         a_len;
   logic [SUM_W-1:0]    a_base, a_need, a_endb, a_lastb;
   logic                issue;
   logic [SUM_W-1:0]    lane_addr [4];
   logic [SUM_W-1:0]    lane_off  [4];
   logic [31:0]         merged;
   logic [SUM_W-1:0]    pos_sum, used_sum;
   logic [15:0]         f_rsize, f_len;
   logic [WORD_AW-1:0]  pos_word;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rd_word   = rd_vld_ff ? rd_data_ff : 32'd0;

   assign a_len   = rec_len(req_data.section_size);
   assign a_base  = SUM_W'(used_ff);
   assign a_need  = a_base + SUM_W'(a_len);
   assign a_endb  = a_base + SUM_W'(8) + SUM_W'(req_data.section_size);
   assign a_lastb = a_endb - SUM_W'(1);
   assign issue   = ptr_ff <= {1'b0, last_ff};

   assign pos_sum  = SUM_W'(pos_ff);
   assign used_sum = SUM_W'(used_ff);
   assign f_rsize  = rd_word[15:0];
   assign f_len    = rec_len(f_rsize);
   assign pos_word = pos_ff[WORD_AW+1:2];

   // Byte merge of one payload word during an append: header bytes first,
   // zero data bytes after them, untouched bytes outside the record.
   always_comb begin
      merged = rd_word;
      for (int k = 0; k < 4; k++) begin
         lane_addr[k] = SUM_W'({wb_addr_ff, 2'(k)});
         lane_off[k]  = lane_addr[k] - base_ff;
         if (lane_addr[k] >= base_ff && lane_addr[k] < endb_ff) begin
            if (lane_addr[k] < hdr_end_ff) begin
               merged[8*k +: 8] = hdr_ff[8*lane_off[k][2:0] +: 8];
            end else begin
               merged[8*k +: 8] = 8'd0;
            end
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      exp_magic_in   = exp_magic_ff;
      exp_version_in = exp_version_ff;
      st_magic_in    = st_magic_ff;
      st_version_in  = st_version_ff;
      used_in        = used_ff;
      ptr_in         = ptr_ff;
      last_in        = last_ff;
      base_in        = base_ff;
      endb_in        = endb_ff;
      hdr_end_in     = hdr_end_ff;
      hdr_in         = hdr_ff;
      wb_valid_in    = 1'b0;
      wb_addr_in     = wb_addr_ff;
      app_used_in    = app_used_ff;
      app_offs_in    = app_offs_ff;
      pos_in         = pos_ff;
      fid_in         = fid_ff;
      fsize_in       = fsize_ff;
      rid_in         = rid_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      clr_all        = 1'b0;
      mem_waddr      = wb_addr_ff;
      mem_raddr      = ptr_ff[WORD_AW-1:0];
      mem_wdata      = merged;
      done           = 1'b0;
      result         = '{status: ST_OK, data_offset: 10'd0};

      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAGIC:   exp_magic_in   = csr_wdata;
            CSR_VERSION: exp_version_in = csr_wdata;
            default:     exp_magic_in   = exp_magic_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.operation)
                  OP_WRITE_WORD: begin
                     done = 1'b1;
                     if (32'(req_data.word_index) < 32'(PAYLOAD_WORDS)) begin
                        mem_we    = 1'b1;
                        mem_waddr = WORD_AW'(req_data.word_index);
                        mem_wdata = req_data.word_data;
                     end
                  end
                  OP_SET_HEADER: begin
                     done          = 1'b1;
                     st_magic_in   = req_data.header_magic;
                     st_version_in = req_data.header_version;
                     used_in       = req_data.header_payload_size;
                  end
                  OP_CLEAR: begin
                     done          = 1'b1;
                     clr_all       = 1'b1;
                     st_magic_in   = exp_magic_ff;
                     st_version_in = exp_version_ff;
                     used_in       = 16'd0;
                  end
                  OP_APPEND: begin
                     if (a_need > CAP_SUM) begin
                        done          = 1'b1;
                        result.status = ST_NO_ROOM;
                     end else begin
                        state_in    = S_APPEND;
                        base_in     = a_base;
                        endb_in     = a_endb;
                        hdr_end_in  = a_base + SUM_W'(8);
                        hdr_in      = {16'd0, req_data.section_size,
                                       req_data.section_id};
                        ptr_in      = a_base[WORD_AW+2:2];
                        last_in     = (a_lastb >= CAP_SUM) ? LAST_WORD
                                                           : a_lastb[WORD_AW+1:2];
                        app_used_in = a_need[15:0];
                        app_offs_in = a_base[9:0] + 10'd8;
                     end
                  end
                  OP_FIND: begin
                     if (st_magic_ff != exp_magic_ff || st_version_ff != exp_version_ff ||
                         used_sum > CAP_SUM) begin
                        done          = 1'b1;
                        result.status = ST_BAD_HEADER;
                     end else begin
                        state_in = S_FLOOP;
                        pos_in   = 16'd0;
                        fid_in   = req_data.section_id;
                        fsize_in = req_data.section_size;
                     end
                  end
                  default: done = 1'b1;
               endcase
            end
         end
         S_APPEND: begin
            // Read word n while the merged word n-1 is written back.
            if (issue) begin
               mem_re      = 1'b1;
               mem_raddr   = ptr_ff[WORD_AW-1:0];
               ptr_in      = ptr_ff + PTR_W'(1);
               wb_valid_in = 1'b1;
               wb_addr_in  = ptr_ff[WORD_AW-1:0];
            end
            if (wb_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wb_addr_ff;
               mem_wdata = merged;
            end
            if (!issue && !wb_valid_ff) begin
               done               = 1'b1;
               result.data_offset = app_offs_ff;
               used_in            = app_used_ff;
               state_in           = S_IDLE;
            end
         end
         S_FLOOP: begin
            if (pos_sum + SUM_W'(8) > used_sum) begin
               done          = 1'b1;
               result.status = ST_NOT_FOUND;
               state_in      = S_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = pos_word;
               state_in  = S_FRID;
            end
         end
         S_FRID: begin
            // The id word is on the read port now; the size word follows.
            rid_in    = rd_word;
            mem_re    = 1'b1;
            mem_raddr = pos_word + WORD_AW'(1);
            state_in  = S_FRSZ;
         end
         S_FRSZ: begin
            state_in = S_FEVAL;
         end
         S_FEVAL: begin
            if (f_rsize == 16'd0 || f_len == 16'd0 ||
                pos_sum + SUM_W'(f_len) > used_sum) begin
               done          = 1'b1;
               result.status = ST_MALFORMED;
               state_in      = S_IDLE;
            end else if (rid_ff == fid_ff) begin
               done     = 1'b1;
               state_in = S_IDLE;
               if (f_rsize != fsize_ff) begin
                  result.status = ST_SIZE_DIFF;
               end else begin
                  result.data_offset = pos_ff[9:0] + 10'd8;
               end
            end else begin
               pos_in   = pos_ff + f_len;
               state_in = S_FLOOP;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = done ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         exp_magic_ff   <= 32'd0;
         exp_version_ff <= 32'd0;
         st_magic_ff    <= 32'd0;
         st_version_ff  <= 32'd0;
         used_ff        <= 16'd0;
         rsp_valid_ff   <= 1'b0;
         wb_valid_ff    <= 1'b0;
         valid_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         exp_magic_ff   <= exp_magic_in;
         exp_version_ff <= exp_version_in;
         st_magic_ff    <= st_magic_in;
         st_version_ff  <= st_version_in;
         used_ff        <= used_in;
         rsp_valid_ff   <= rsp_valid_in;
         wb_valid_ff    <= wb_valid_in;
         if (clr_all) begin
            valid_ff <= '0;
         end else if (mem_we) begin
            valid_ff[mem_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      ptr_ff      <= ptr_in;
      last_ff     <= last_in;
      base_ff     <= base_in;
      endb_ff     <= endb_in;
      hdr_end_ff  <= hdr_end_in;
      hdr_ff      <= hdr_in;
      wb_addr_ff  <= wb_addr_in;
      app_used_ff <= app_used_in;
      app_offs_ff <= app_offs_in;
      pos_ff      <= pos_in;
      fid_ff      <= fid_in;
      fsize_ff    <= fsize_in;
      rid_ff      <= rid_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_q[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_q[mem_raddr];
         rd_vld_ff  <= valid_ff[mem_raddr];
      end
   end

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready)
      else $error("request taken while an operation is in progress");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      mem_we && mem_re |-> mem_waddr != mem_raddr)
      else $error("payload read and write hit the same word");

   a_wb_in_range: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> state_ff == S_APPEND && wb_addr_ff <= last_ff)
      else $error("append write-back outside the record span");

   a_walk_in_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FEVAL |-> pos_sum + SUM_W'(8) <= used_sum)
      else $error("record walk past the used bytes");

endmodule
